/* rtl/simon64_128_block_cipher_macros.svh */
// assertion macros, sampled on clk and quiet while arst_n is low
`ifndef SIMON64_128_BLOCK_CIPHER_MACROS_SVH
`define SIMON64_128_BLOCK_CIPHER_MACROS_SVH

// condition that holds at every edge
`define SIMON_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define SIMON_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/simon_pkg.sv */
`timescale 1ns / 1ps
package simon_pkg;

	localparam int ROUNDS = 44;
	localparam int RK_AW = $clog2(ROUNDS);
	localparam int WORD_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int KEY_WORDS = 4;

	localparam logic [RK_AW-1:0] LAST_RND = RK_AW'(ROUNDS - 1);

	localparam logic [63:0] Z3_SEQ = 64'hfc2ce51207a635db;
	localparam logic [WORD_W-1:0] KS_CONST = 32'hfffffffc;
	localparam logic [WORD_W-1:0] IV_RESET = 32'd1251663163;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CBC = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IV = 3'd6;

	typedef struct packed {
		logic [WORD_W-1:0] block_high;
		logic [WORD_W-1:0] block_low;
		logic message_start;
		logic decrypt;
		logic cbc;
	} item_t;

	typedef struct packed {
		logic run;
		logic [RK_AW-1:0] rnd;
		logic [RK_AW-1:0] key_addr;
	} eng_status_t;

	function automatic logic [WORD_W-1:0] simon_f(input logic [WORD_W-1:0] v);
		simon_f = ({v[30:0], v[31]} & {v[23:0], v[31:24]}) ^ {v[29:0], v[31:30]};
	endfunction

endpackage

/* rtl/simon64_128_block_cipher.sv */
`timescale 1ns / 1ps
// Simon 64/128 block cipher, ECB or CBC, encrypt or decrypt chosen by register.
// Blocks enter through a two-entry input queue and leave through a result
// register, so both sides stall independently. A block leaving the input queue
// goes through one key fetch, then 44 rounds of the single round unit at one
// round per cycle (the round key memory feeds one key per cycle), then posts its
// result once the result register is free or popped; blocks are processed one at
// a time, so a new block is not taken until the last one is posted.
// After reset and after every key word write the round keys are rebuilt, and
// full stays high while they are.
`include "simon64_128_block_cipher_macros.svh"
module simon64_128_block_cipher import simon_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [WORD_W-1:0]    block_low,
	input  logic [WORD_W-1:0]    block_high,
	input  logic                 message_start,
	output logic                 empty,
	input  logic                 pop,
	output logic [WORD_W-1:0]    result_low,
	output logic [WORD_W-1:0]    result_high
);

	logic              decrypt_q;
	logic              cbc_q;
	logic [WORD_W-1:0] iv_q;
	item_t             in_item;
	item_t             q_item;
	logic              q_valid;
	logic [1:0]        q_count;
	logic              q_take;
	logic              ks_busy;
	logic [RK_AW-1:0]  key_addr;
	logic [WORD_W-1:0] key_data;
	logic              res_valid;
	eng_status_t       eng_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
			cbc_q <= 1'b0;
			iv_q <= IV_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DECRYPT: decrypt_q <= cfg_data[0];
				REG_CBC: cbc_q <= cfg_data[0];
				REG_IV: iv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// tag each block with its mode on transfer
	assign in_item.block_high = block_high;
	assign in_item.block_low = block_low;
	assign in_item.message_start = message_start;
	assign in_item.decrypt = decrypt_q;
	assign in_item.cbc = cbc_q;

	assign full = (q_count == 2'd2) || ks_busy;

	simon_keysched u_keysched (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_addr   (key_addr),
		.rd_data   (key_data),
		.busy      (ks_busy)
	);

	simon_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push && !full),
		.push_data (in_item),
		.pop       (q_take),
		.pop_data  (q_item),
		.not_empty (q_valid),
		.count     (q_count)
	);

	simon_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.item_valid (q_valid),
		.item_take  (q_take),
		.iv         (iv_q),
		.keys_busy  (ks_busy),
		.key_addr   (key_addr),
		.key_data   (key_data),
		.res_pop    (pop),
		.res_valid  (res_valid),
		.res_low    (result_low),
		.res_high   (result_high),
		.status     (eng_status)
	);

	assign empty = !res_valid;

	`SIMON_ASSERT_ALWAYS(a_queue_bound, q_count <= 2'd2, "input queue overfilled")
	`SIMON_ASSERT_IMPL(a_round_bound, eng_status.run, eng_status.rnd < RK_AW'(ROUNDS), "round out of range")
	`SIMON_ASSERT_IMPL(a_key_addr, eng_status.run, eng_status.key_addr < RK_AW'(ROUNDS), "key address out of range")

endmodule

/* rtl/simon_keysched.sv */
`timescale 1ns / 1ps
module simon_keysched import simon_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic [RK_AW-1:0]     rd_addr,
	output logic [WORD_W-1:0]    rd_data,
	output logic                 busy
);

	logic [WORD_W-1:0] key_q [KEY_WORDS];
	logic [WORD_W-1:0] win_q [KEY_WORDS];
	logic [WORD_W-1:0] mem [ROUNDS];
	logic [WORD_W-1:0] rd_data_q;
	logic              busy_q;
	logic [RK_AW-1:0]  idx_q;
	logic [RK_AW-1:0]  z_idx;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] new_rk;
	logic              key_wr;

	assign key_wr = cfg_write && (cfg_index <= REG_KEY3);
	assign z_idx = idx_q - RK_AW'(KEY_WORDS);
	assign t1 = {win_q[3][2:0], win_q[3][31:3]} ^ win_q[1];
	assign t2 = t1 ^ {t1[0], t1[31:1]};
	assign new_rk = (idx_q < RK_AW'(KEY_WORDS)) ? key_q[idx_q[1:0]] :
		KS_CONST ^ {31'b0, Z3_SEQ[z_idx]} ^ win_q[0] ^ t2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (key_wr) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (busy_q) begin
			if (idx_q == LAST_RND) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (key_wr) begin
			key_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	// window of the four latest round keys
	always_ff @(posedge clk) begin
		if (busy_q) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= new_rk;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[idx_q] <= new_rk;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign busy = busy_q;

endmodule

/* rtl/simon_queue.sv */
`timescale 1ns / 1ps
module simon_queue import simon_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_data,
	input  logic  pop,
	output item_t pop_data,
	output logic  not_empty,
	output logic  [1:0] count
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign do_push = push && (count_q != 2'd2);
	assign do_pop = pop && (count_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = slot_q[rd_ptr_q];
	assign not_empty = (count_q != 2'd0);
	assign count = count_q;

endmodule

/* rtl/simon_engine.sv */
`timescale 1ns / 1ps
module simon_engine import simon_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             item,
	input  logic              item_valid,
	output logic              item_take,
	input  logic [WORD_W-1:0] iv,
	input  logic              keys_busy,
	output logic [RK_AW-1:0]  key_addr,
	input  logic [WORD_W-1:0] key_data,
	input  logic              res_pop,
	output logic              res_valid,
	output logic [WORD_W-1:0] res_low,
	output logic [WORD_W-1:0] res_high,
	output eng_status_t       status
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_DONE  = 4'b1000
	} eng_state_t;

	eng_state_t        state_q;
	logic [RK_AW-1:0]  rnd_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic [63:0]       cin_q;
	logic [63:0]       chain_q;
	logic              dec_q;
	logic              cbc_q;
	logic              res_valid_q;
	logic [WORD_W-1:0] res_low_q;
	logic [WORD_W-1:0] res_high_q;
	logic [63:0]       chain_eff;
	logic [RK_AW-1:0]  next_rnd;
	logic [RK_AW-1:0]  addr_rnd;
	logic              take;
	logic              finish;

	assign take = (state_q == ST_IDLE) && item_valid && !keys_busy;
	assign finish = (state_q == ST_DONE) && (!res_valid_q || res_pop);
	assign chain_eff = item.message_start ? {iv, iv} : chain_q;
	assign next_rnd = (rnd_q == LAST_RND) ? '0 : rnd_q + 1'b1;
	assign addr_rnd = (state_q == ST_RUN) ? next_rnd : '0;
	assign key_addr = dec_q ? LAST_RND - addr_rnd : addr_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			chain_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_FETCH;
						rnd_q <= '0;
						chain_q <= chain_eff;
					end
				end
				ST_FETCH: state_q <= ST_RUN;
				ST_RUN: begin
					rnd_q <= next_rnd;
					if (rnd_q == LAST_RND) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (cbc_q) begin
							chain_q <= dec_q ? cin_q : {x_q, y_q};
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dec_q <= item.decrypt;
			cbc_q <= item.cbc;
			cin_q <= {item.block_high, item.block_low};
			if (!item.decrypt && item.cbc) begin
				x_q <= item.block_high ^ chain_eff[63:32];
				y_q <= item.block_low ^ chain_eff[31:0];
			end else begin
				x_q <= item.block_high;
				y_q <= item.block_low;
			end
		end else if (state_q == ST_RUN) begin
			if (dec_q) begin
				y_q <= x_q ^ simon_f(y_q) ^ key_data;
				x_q <= y_q;
			end else begin
				x_q <= y_q ^ simon_f(x_q) ^ key_data;
				y_q <= x_q;
			end
		end
		if (finish) begin
			if (dec_q && cbc_q) begin
				res_low_q <= y_q ^ chain_q[31:0];
				res_high_q <= x_q ^ chain_q[63:32];
			end else begin
				res_low_q <= y_q;
				res_high_q <= x_q;
			end
		end
	end

	assign item_take = take;
	assign res_valid = res_valid_q;
	assign res_low = res_low_q;
	assign res_high = res_high_q;
	assign status.run = (state_q == ST_RUN);
	assign status.rnd = rnd_q;
	assign status.key_addr = key_addr;

endmodule

/* tb/simon64_128_block_cipher_tb.sv */
`timescale 1ns / 1ps
module simon64_128_block_cipher_tb;
	import simon_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_BLOCKS = 1800;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic {ROW_CFG, ROW_BLOCK} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [WORD_W-1:0] data;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		logic start;
		logic known;
		logic [WORD_W-1:0] want_lo;
		logic [WORD_W-1:0] want_hi;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [WORD_W-1:0] block_low = '0;
	logic [WORD_W-1:0] block_high = '0;
	logic message_start = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [WORD_W-1:0] result_low;
	logic [WORD_W-1:0] result_high;

	// cipher state as the block should hold it
	logic [WORD_W-1:0] key_words[KEY_WORDS];
	logic [WORD_W-1:0] sched[ROUNDS];
	logic decrypting;
	logic chained;
	logic [WORD_W-1:0] iv_word;
	logic [63:0] chain_word;

	logic [63:0] pending_blocks[$];
	int failures = 0;
	int cycles = 0;
	int random_sent = 0;
	int stall_left = 0;
	bit stall_request = 1'b0;
	bit quiet = 1'b0;

	simon64_128_block_cipher u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.block_low(block_low),
		.block_high(block_high),
		.message_start(message_start),
		.empty(empty),
		.pop(pop),
		.result_low(result_low),
		.result_high(result_high)
	);

	always #5 clk = ~clk;

	function automatic logic [WORD_W-1:0] rot_l(input logic [WORD_W-1:0] v, input int s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

	function automatic logic [WORD_W-1:0] rot_r(input logic [WORD_W-1:0] v, input int s);
		return (v >> s) | (v << (WORD_W - s));
	endfunction

	function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] v);
		return (rot_l(v, 1) & rot_l(v, 8)) ^ rot_l(v, 2);
	endfunction

	function automatic void rebuild_schedule();
		logic [WORD_W-1:0] t;
		logic [63:0] z;
		z = Z3_SEQ;
		for (int i = 0; i < KEY_WORDS; i++)
			sched[i] = key_words[i];
		for (int i = KEY_WORDS; i < ROUNDS; i++) begin
			t = rot_r(sched[i-1], 3) ^ sched[i-3];
			t ^= rot_r(t, 1);
			sched[i] = KS_CONST ^ {31'b0, z[0]} ^ sched[i-4] ^ t;
			z = z >> 1;
		end
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [WORD_W-1:0] data);
		if (idx <= REG_KEY3) begin
			key_words[idx] = data;
			rebuild_schedule();
		end else if (idx == REG_DECRYPT) begin
			decrypting = data[0];
		end else if (idx == REG_CBC) begin
			chained = data[0];
		end else if (idx == REG_IV) begin
			iv_word = data;
		end
	endfunction

	function automatic logic [63:0] cipher_block(input logic [WORD_W-1:0] lo,
			input logic [WORD_W-1:0] hi, input logic start);
		logic [WORD_W-1:0] x, y, t, cx, cy;
		logic [63:0] cin;
		y = lo;
		x = hi;
		if (start)
			chain_word = {iv_word, iv_word};
		cy = chain_word[31:0];
		cx = chain_word[63:32];
		if (!decrypting) begin
			if (chained) begin
				y ^= cy;
				x ^= cx;
			end
			for (int r = 0; r < ROUNDS; r++) begin
				t = x;
				x = y ^ round_mix(x) ^ sched[r];
				y = t;
			end
			if (chained)
				chain_word = {x, y};
		end else begin
			cin = {x, y};
			for (int r = ROUNDS - 1; r >= 0; r--) begin
				t = y;
				y = x ^ round_mix(y) ^ sched[r];
				x = t;
			end
			if (chained) begin
				y ^= cy;
				x ^= cx;
				chain_word = cin;
			end
		end
		return {x, y};
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(31);
			3: return ~(32'h1 << $urandom_range(31));
			default: return $urandom();
		endcase
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [WORD_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic stim_row_t blk_row(input logic [WORD_W-1:0] lo,
			input logic [WORD_W-1:0] hi, input logic start);
		stim_row_t r;
		r = '0;
		r.kind = ROW_BLOCK;
		r.lo = lo;
		r.hi = hi;
		r.start = start;
		return r;
	endfunction

	function automatic stim_row_t known_row(input logic [WORD_W-1:0] lo,
			input logic [WORD_W-1:0] hi, input logic start,
			input logic [WORD_W-1:0] want_lo, input logic [WORD_W-1:0] want_hi);
		stim_row_t r;
		r = blk_row(lo, hi, start);
		r.known = 1'b1;
		r.want_lo = want_lo;
		r.want_hi = want_hi;
		return r;
	endfunction

	task automatic sender_gap();
		while (!quiet && $urandom_range(99) < 7) begin
			push <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_block(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
			input logic start, input logic known, input logic [63:0] want);
		logic [63:0] pred;
		push <= 1'b1;
		block_low <= lo;
		block_high <= hi;
		message_start <= start;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pred = cipher_block(lo, hi, start);
		pending_blocks.push_back(known ? want : pred);
	endtask

	task automatic drain();
		push <= 1'b0;
		do
			@(posedge clk);
		while (pending_blocks.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		apply_reg(idx, data);
		@(posedge clk);
		// key write restarts the schedule build
		if (idx <= REG_KEY3)
			while (full)
				@(posedge clk);
	endtask

	// result side: check each transfer, idle at random and hold off on request
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && pop && !empty) begin
			if (pending_blocks.size() == 0) begin
				$error("unexpected result: result_high %h, result_low %h",
					result_high, result_low);
				failures++;
			end else begin
				want = pending_blocks.pop_front();
				if (result_low !== want[31:0]) begin
					$error("result_low: expected %h, got %h", want[31:0], result_low);
					failures++;
				end
				if (result_high !== want[63:32]) begin
					$error("result_high: expected %h, got %h", want[63:32], result_high);
					failures++;
				end
			end
		end
		if (stall_request) begin
			stall_left = HOLD_OFF_CYCLES;
			stall_request = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else begin
			pop <= quiet || ($urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		int phase;
		int blocks_left;
		int msg_len;
		int in_phase;
		bit well_formed;
		logic start;

		for (int i = 0; i < KEY_WORDS; i++)
			key_words[i] = '0;
		decrypting = 1'b0;
		chained = 1'b0;
		iv_word = IV_RESET;
		chain_word = '0;
		rebuild_schedule();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// zero key after reset, field extremes
		rows.push_back(blk_row(32'h0, 32'h0, 1'b0));
		rows.push_back(blk_row(32'hffffffff, 32'hffffffff, 1'b0));
		rows.push_back(blk_row(32'h0, 32'hffffffff, 1'b0));
		rows.push_back(blk_row(32'hffffffff, 32'h0, 1'b0));
		// published test vector
		rows.push_back(cfg_row(REG_KEY0, 32'h03020100));
		rows.push_back(cfg_row(REG_KEY0 + 3'd1, 32'h0b0a0908));
		rows.push_back(cfg_row(REG_KEY0 + 3'd2, 32'h13121110));
		rows.push_back(cfg_row(REG_KEY3, 32'h1b1a1918));
		rows.push_back(known_row(32'h20646e75, 32'h656b696c, 1'b0,
			32'hb9dfa07a, 32'h44c8fc20));
		// cbc with the chain still zero from reset
		rows.push_back(cfg_row(REG_CBC, 32'h1));
		rows.push_back(known_row(32'h20646e75, 32'h656b696c, 1'b0,
			32'hb9dfa07a, 32'h44c8fc20));
		rows.push_back(blk_row(32'h20646e75, 32'h656b696c, 1'b1));
		rows.push_back(blk_row(32'h89abcdef, 32'h01234567, 1'b0));
		rows.push_back(blk_row(32'h0, 32'h0, 1'b0));
		rows.push_back(cfg_row(REG_DECRYPT, 32'h1));
		rows.push_back(cfg_row(REG_CBC, 32'h0));
		rows.push_back(known_row(32'hb9dfa07a, 32'h44c8fc20, 1'b0,
			32'h20646e75, 32'h656b696c));
		// ecb message start loads the chain without using it
		rows.push_back(blk_row(32'h0, 32'h0, 1'b1));
		rows.push_back(cfg_row(REG_CBC, 32'h1));
		rows.push_back(blk_row(32'h55aa55aa, 32'haa55aa55, 1'b0));
		rows.push_back(blk_row(32'h13579bdf, 32'h2468ace0, 1'b1));
		rows.push_back(blk_row(32'hfedcba98, 32'h76543210, 1'b0));
		rows.push_back(cfg_row(REG_IV, 32'h0));
		rows.push_back(blk_row(32'h00001234, 32'h00005678, 1'b1));
		rows.push_back(blk_row(32'h0000abcd, 32'h0000ef01, 1'b0));
		rows.push_back(cfg_row(REG_IV, 32'hffffffff));
		rows.push_back(cfg_row(REG_DECRYPT, 32'h0));
		rows.push_back(blk_row(32'hffffffff, 32'hffffffff, 1'b1));
		rows.push_back(blk_row(32'h0, 32'h0, 1'b0));
		// unknown index is ignored
		rows.push_back(cfg_row(REG_UNUSED, 32'hffffffff));
		rows.push_back(cfg_row(REG_KEY0, 32'hffffffff));
		rows.push_back(cfg_row(REG_KEY0 + 3'd1, 32'hffffffff));
		rows.push_back(cfg_row(REG_KEY0 + 3'd2, 32'hffffffff));
		rows.push_back(cfg_row(REG_KEY3, 32'hffffffff));
		rows.push_back(blk_row(32'h0, 32'h0, 1'b1));
		rows.push_back(blk_row(32'hffffffff, 32'hffffffff, 1'b0));
		rows.push_back(cfg_row(REG_DECRYPT, 32'h1));
		rows.push_back(blk_row(32'hdeadbeef, 32'hcafef00d, 1'b1));
		rows.push_back(blk_row(32'h0f0f0f0f, 32'hf0f0f0f0, 1'b0));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				sender_gap();
				send_block(rows[i].lo, rows[i].hi, rows[i].start, rows[i].known,
					{rows[i].want_hi, rows[i].want_lo});
			end
		end

		phase = 0;
		while (random_sent < RANDOM_BLOCKS) begin
			drain();
			if ($urandom_range(3) == 0)
				write_reg(REG_UNUSED, pick_word());
			write_reg(REG_DECRYPT, pick_word());
			write_reg(REG_CBC, pick_word());
			if ($urandom_range(1) == 0)
				write_reg(REG_IV, pick_word());
			for (int k = 0; k < KEY_WORDS; k++)
				if ($urandom_range(2) == 0)
					write_reg(REG_KEY0 + CFG_IDX_W'(k), pick_word());

			if (phase == 8)
				quiet = 1'b1;
			if (phase == 11)
				quiet = 1'b0;
			if (phase == 3)
				blocks_left = 60;
			else if ($urandom_range(11) == 0)
				blocks_left = 150;
			else
				blocks_left = $urandom_range(10, 60);

			in_phase = 0;
			while (blocks_left > 0) begin
				msg_len = $urandom_range(1, 12);
				well_formed = ($urandom_range(99) < 85);
				for (int k = 0; k < msg_len && blocks_left > 0; k++) begin
					start = well_formed ? (k == 0) : 1'($urandom_range(1));
					sender_gap();
					send_block(pick_word(), pick_word(), start, 1'b0, '0);
					blocks_left--;
					in_phase++;
					random_sent++;
					// hold off the result side so that the input stalls
					if (phase == 3 && in_phase == 4)
						stall_request = 1'b1;
					// sender waits for all results, which may fall mid-message
					if (phase == 5 && in_phase == 10)
						drain();
				end
			end
			phase++;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_blocks.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
